FILE: design/cce_pkg.sv
// ----------------------------------------------------------------------------
// C character escape emitter package
// Shared widths, byte constants, types and small lookup functions.
// ----------------------------------------------------------------------------
package cce_pkg;

   localparam int CodeWidth  = 32;
   localparam int ByteWidth  = 8;
   localparam int MaxBytes   = 10;
   localparam int CountWidth = $clog2(MaxBytes + 1);

   localparam logic [ByteWidth-1:0] ChBackslash = 8'h5C;
   localparam logic [ByteWidth-1:0] ChZero      = 8'h30;
   localparam logic [ByteWidth-1:0] ChUpperU    = 8'h55;
   localparam logic [ByteWidth-1:0] ChLowerU    = 8'h75;
   localparam logic [ByteWidth-1:0] ChUpperA    = 8'h41;
   localparam logic [ByteWidth-1:0] ChNone      = 8'h00;

   localparam logic [CodeWidth-1:0] FirstPrintable = 32'd32;
   localparam logic [CodeWidth-1:0] LastPrintable  = 32'd126;
   localparam logic [CodeWidth-1:0] LastBmp        = 32'h0000_FFFF;

   localparam logic [CountWidth-1:0] CountOne   = CountWidth'(1);
   localparam logic [CountWidth-1:0] CountTwo   = CountWidth'(2);
   localparam logic [CountWidth-1:0] CountThree = CountWidth'(3);
   localparam logic [CountWidth-1:0] CountSix   = CountWidth'(6);
   localparam logic [CountWidth-1:0] CountTen   = CountWidth'(10);

   typedef logic [MaxBytes-1:0][ByteWidth-1:0] byte_array_type;

   // Uppercase hex digit for one nibble.
   function automatic logic [ByteWidth-1:0] hex_char(input logic [3:0] nib);
      logic [ByteWidth-1:0] ch;
      if (nib < 4'd10) begin
         ch = ChZero + {4'h0, nib};
      end else begin
         ch = ChUpperA + {4'h0, nib - 4'd10};
      end
      return ch;
   endfunction

   // Character that follows the backslash for the simple escapes,
   // or ChNone when the code has no simple escape.
   function automatic logic [ByteWidth-1:0] simple_escape(input logic [CodeWidth-1:0] c);
      logic [ByteWidth-1:0] ch;
      case (c)
         32'd39:  ch = 8'h27;
         32'd34:  ch = 8'h22;
         32'd63:  ch = 8'h3F;
         32'd92:  ch = 8'h5C;
         32'd7:   ch = 8'h61;
         32'd8:   ch = 8'h62;
         32'd12:  ch = 8'h66;
         32'd10:  ch = 8'h6E;
         32'd13:  ch = 8'h72;
         32'd9:   ch = 8'h74;
         32'd11:  ch = 8'h76;
         default: ch = ChNone;
      endcase
      return ch;
   endfunction

endpackage

FILE: design/cce_if.sv
// ----------------------------------------------------------------------------
// C character escape emitter channels
// Valid/ready channels for character codes in and spelled bytes out.
// ----------------------------------------------------------------------------
interface cce_req_if;
   logic                             valid;
   logic                             ready;
   logic [cce_pkg::CodeWidth-1:0]    code_point;

   modport source (output valid, output code_point, input ready);
   modport sink   (input valid, input code_point, output ready);
endinterface

interface cce_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cce_pkg::ByteWidth-1:0]    out_byte;
   logic                             last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: design/c_char_escape_emitter_unit.sv
// ----------------------------------------------------------------------------
// C character escape emitter
// Spells each 32-bit character code as C source bytes, one byte per transaction.
// ----------------------------------------------------------------------------
// Pipeline: a code passes through the capture, format and output stages before
// its first byte is presented on the output port.
// Throughput: one output byte per cycle while rsp.ready is high; a character is
// spelled as 1 to 10 bytes, sent one at a time by the shifting output stage.
// A new code is accepted in every cycle while the stages ahead have room.
// Reset: synchronous, active high; clears all stage valid bits.
module c_char_escape_emitter_unit (
   input  logic          clock,
   input  logic          reset,
   cce_req_if.sink       req,
   cce_rsp_if.source     rsp
);

   // Stage 1: captured character code.
   logic                              s1_valid_ff, s1_valid_in;
   logic [cce_pkg::CodeWidth-1:0]     s1_code_ff, s1_code_in;

   // Stage 2: fully formatted spelling and its length.
   logic                              s2_valid_ff, s2_valid_in;
   cce_pkg::byte_array_type           s2_bytes_ff, s2_bytes_in;
   logic [cce_pkg::CountWidth-1:0]    s2_count_ff, s2_count_in;

   // Stage 3: output shift register; byte zero is on the output port.
   logic                              s3_valid_ff, s3_valid_in;
   cce_pkg::byte_array_type           s3_bytes_ff, s3_bytes_in;
   logic [cce_pkg::CountWidth-1:0]    s3_count_ff, s3_count_in;

   logic                              s3_last;
   logic                              s3_load;
   logic                              s2_adv;
   logic                              s1_adv;

   // Formatter outputs (combinational, between stage 1 and stage 2).
   cce_pkg::byte_array_type           fmt_bytes;
   logic [cce_pkg::CountWidth-1:0]    fmt_count;
   logic [cce_pkg::ByteWidth-1:0]     fmt_esc;

   // ------------------------------------------------------------------------
   // Flow control. The output stage takes a new spelling when it is empty or
   // when its final byte leaves in this cycle, so characters follow each
   // other without a gap. Each earlier stage advances when the next stage
   // takes its contents or when it holds nothing.
   // ------------------------------------------------------------------------
   assign s3_last = (s3_count_ff == cce_pkg::CountOne);
   assign s3_load = !s3_valid_ff || (rsp.ready && s3_last);
   assign s2_adv  = s3_load || !s2_valid_ff;
   assign s1_adv  = s2_adv || !s1_valid_ff;

   assign req.ready = s1_adv;

   assign rsp.valid     = s3_valid_ff;
   assign rsp.out_byte  = s3_bytes_ff[0];
   assign rsp.last_byte = s3_last;

   // ------------------------------------------------------------------------
   // Stage 1: register the incoming code.
   // ------------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_code_in  = s1_code_ff;
      if (s1_adv) begin
         s1_valid_in = req.valid;
         s1_code_in  = req.code_point;
      end
   end

   // ------------------------------------------------------------------------
   // Formatter. The spelling is picked by class of the code: a simple escape,
   // an octal escape for the remaining control codes, a universal character
   // name for anything above the printable range, or the code itself. The
   // octal form drops its leading zero, so codes below eight give one digit.
   // ------------------------------------------------------------------------
   always_comb begin
      fmt_esc   = cce_pkg::simple_escape(s1_code_ff);
      fmt_bytes = '0;
      fmt_count = cce_pkg::CountOne;
      fmt_bytes[0] = cce_pkg::ChBackslash;
      if (fmt_esc != cce_pkg::ChNone) begin
         fmt_bytes[1] = fmt_esc;
         fmt_count    = cce_pkg::CountTwo;
      end else if (s1_code_ff < cce_pkg::FirstPrintable) begin
         if (s1_code_ff[4:3] != 2'b00) begin
            fmt_bytes[1] = cce_pkg::ChZero + {6'h00, s1_code_ff[4:3]};
            fmt_bytes[2] = cce_pkg::ChZero + {5'h00, s1_code_ff[2:0]};
            fmt_count    = cce_pkg::CountThree;
         end else begin
            fmt_bytes[1] = cce_pkg::ChZero + {5'h00, s1_code_ff[2:0]};
            fmt_count    = cce_pkg::CountTwo;
         end
      end else if (s1_code_ff > cce_pkg::LastBmp) begin
         fmt_bytes[1] = cce_pkg::ChUpperU;
         for (int k = 0; k < 8; k++) begin
            fmt_bytes[2 + k] = cce_pkg::hex_char(s1_code_ff[(7 - k) * 4 +: 4]);
         end
         fmt_count = cce_pkg::CountTen;
      end else if (s1_code_ff > cce_pkg::LastPrintable) begin
         fmt_bytes[1] = cce_pkg::ChLowerU;
         for (int k = 0; k < 4; k++) begin
            fmt_bytes[2 + k] = cce_pkg::hex_char(s1_code_ff[(3 - k) * 4 +: 4]);
         end
         fmt_count = cce_pkg::CountSix;
      end else begin
         fmt_bytes[0] = s1_code_ff[cce_pkg::ByteWidth-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: hold the formatted spelling.
   // ------------------------------------------------------------------------
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_bytes_in = s2_bytes_ff;
      s2_count_in = s2_count_ff;
      if (s2_adv) begin
         s2_valid_in = s1_valid_ff;
         s2_bytes_in = fmt_bytes;
         s2_count_in = fmt_count;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: each accepted output transaction shifts the next byte into
   // place; after the final byte a new spelling loads, or the stage empties.
   // ------------------------------------------------------------------------
   always_comb begin
      s3_valid_in = s3_valid_ff;
      s3_bytes_in = s3_bytes_ff;
      s3_count_in = s3_count_ff;
      if (s3_load) begin
         s3_valid_in = s2_valid_ff;
         s3_bytes_in = s2_bytes_ff;
         s3_count_in = s2_count_ff;
      end else if (rsp.ready) begin
         s3_bytes_in = {cce_pkg::ChNone, s3_bytes_ff[cce_pkg::MaxBytes-1:1]};
         s3_count_in = s3_count_ff - cce_pkg::CountOne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_code_ff  <= s1_code_in;
      s2_bytes_ff <= s2_bytes_in;
      s2_count_ff <= s2_count_in;
      s3_bytes_ff <= s3_bytes_in;
      s3_count_ff <= s3_count_in;
   end

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // A character is never cut short: after a non-final byte leaves, more follow.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !rsp.last_byte |=> rsp.valid)
      else $error("spelling ended without a final byte");

   // The output stage never holds an empty spelling.
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_count_ff != '0) && (s3_count_ff <= cce_pkg::CountTen))
      else $error("output stage byte count out of range");

   // A stalled capture stage keeps its code.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> $stable(s1_code_ff) && s1_valid_ff)
      else $error("stalled code was lost");

   // Formatted spellings are never overwritten while waiting.
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_adv |=> s2_valid_ff && $stable(s2_count_ff))
      else $error("stalled spelling was lost");

endmodule
